/* src/flp_pkg.sv */
// Package: shared constants and beat types for the FIFO/LRU page replacement block
`timescale 1ns / 1ps
package flp_pkg;

    localparam int MAX_FRAMES = 32;
    localparam int PAGE_BITS  = 16;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int LIMIT_W    = 6;
    localparam int CFG_W      = 6;

    localparam logic CFG_POLICY_MODE = 1'b0;
    localparam logic CFG_FRAME_LIMIT = 1'b1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page_number;
        logic                 restart;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [CNT_W-1:0]     occupancy;
    } t_out;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 move_en;
        logic                 evict;
    } t_cell_ctl;

endpackage

/* src/flp_cell.sv */
// Frame cell: one resident page, its compare and its shift towards the oldest end
`timescale 1ns / 1ps
module flp_cell (
    input  logic                          i_clk,
    input  flp_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_live,
    input  logic                          i_next_live,
    input  logic                          i_wr_here,
    input  logic [flp_pkg::PAGE_BITS-1:0] i_next_page,
    input  logic                          i_chain,
    output logic                          o_chain,
    output logic [flp_pkg::PAGE_BITS-1:0] o_page
);

    logic [flp_pkg::PAGE_BITS-1:0] r_page;
    logic [flp_pkg::PAGE_BITS-1:0] n_page;
    logic                          match;
    logic                          take_next;

    assign match     = i_live && (r_page == i_ctl.page);
    assign o_chain   = i_chain | match;
    assign take_next = i_ctl.move_en && (i_ctl.evict || o_chain) && i_next_live;

    always_comb begin
        n_page = r_page;
        if (take_next) begin
            n_page = i_next_page;
        end else if (i_wr_here) begin
            n_page = i_ctl.page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

    assign o_page = r_page;

endmodule

/* src/fifo_lru_page_replacement.sv */
// Top level: row of frame cells with occupancy count, policy registers and output register
// The result of an accepted reference is registered and shows at the output in the next cycle.
// Throughput: one reference per cycle while o_in_stall is low; all frame cells compare and shift in the same cycle.
// The ordered frame list moves one cell towards the oldest end on eviction or LRU hit.
// Reset (synchronous, active low) empties the frames, selects FIFO and a frame limit of 32.
// Frame contents are not cleared; the occupancy count alone marks which cells are live.
`timescale 1ns / 1ps
module fifo_lru_page_replacement (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  flp_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output flp_pkg::t_out             o_out_data,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [flp_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int N = flp_pkg::MAX_FRAMES;
    localparam int W = flp_pkg::CNT_W;

    logic                            r_mode;
    logic [flp_pkg::LIMIT_W-1:0]     r_limit;
    logic [W-1:0]                    r_used;
    logic [W-1:0]                    n_used;
    logic                            r_out_valid;
    flp_pkg::t_out                   r_out;
    flp_pkg::t_out                   n_out;

    logic                            in_acc;
    logic [W-1:0]                    u;
    logic [W-1:0]                    lim;
    logic                            found;
    logic                            lru_hit;
    logic                            evict;
    logic                            do_write;
    logic [W-1:0]                    wpos;
    flp_pkg::t_cell_ctl              ctl;

    logic [N:0]                      chain;
    logic [N:0]                      live;
    logic [flp_pkg::PAGE_BITS-1:0]   page_q [N+1];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign u = i_in_data.restart ? '0 : r_used;

    always_comb begin
        if (r_limit == '0) begin
            lim = W'(1);
        end else if (W'(r_limit) > W'(N) || ((flp_pkg::LIMIT_W > W) && (r_limit >> W) != '0)) begin
            lim = W'(N);
        end else begin
            lim = W'(r_limit);
        end
    end

    assign found    = chain[N];
    assign lru_hit  = found && (r_mode == flp_pkg::MODE_LRU);
    assign evict    = !found && (u >= lim) && (u != '0);
    assign do_write = in_acc && (!found || lru_hit);
    assign wpos     = (lru_hit || evict) ? (u - W'(1)) : u;

    assign ctl.page    = i_in_data.page_number;
    assign ctl.move_en = in_acc && (lru_hit || evict);
    assign ctl.evict   = evict;

    assign chain[0]  = 1'b0;
    assign live[N]   = 1'b0;
    assign page_q[N] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        localparam logic [W-1:0] K = W'(i);
        assign live[i] = u > K;
        flp_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_live      (live[i]),
            .i_next_live (live[i+1]),
            .i_wr_here   (do_write && (wpos == K)),
            .i_next_page (page_q[i+1]),
            .i_chain     (chain[i]),
            .o_chain     (chain[i+1]),
            .o_page      (page_q[i])
        );
    end

    always_comb begin
        n_used = r_used;
        if (in_acc) begin
            n_used = (!found && !evict) ? (u + W'(1)) : u;
        end
        n_out.hit           = found;
        n_out.evicted_valid = evict;
        n_out.evicted_page  = evict ? page_q[0] : '0;
        n_out.occupancy     = n_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= flp_pkg::MODE_FIFO;
            r_limit     <= flp_pkg::LIMIT_W'(N);
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    flp_pkg::CFG_POLICY_MODE: r_mode  <= i_cfg_data[0];
                    flp_pkg::CFG_FRAME_LIMIT: r_limit <= flp_pkg::LIMIT_W'(i_cfg_data);
                    default: ;
                endcase
            end
            r_used <= n_used;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= W'(N))
        else $error("frame count above frame total");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.restart |=> r_used == W'(1) && !r_out.hit && !r_out.evicted_valid)
        else $error("restart beat did not leave a single frame");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.evicted_valid |-> !r_out.hit && r_out.occupancy != '0)
        else $error("eviction reported on a hit or with no frames");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && found |=> r_used == $past(u))
        else $error("hit changed the frame count");

endmodule

/* tb/sv/tb_fifo_lru_page_replacement.sv */
// Testbench: directed and random page references against a FIFO/LRU replacement predictor
`timescale 1ns / 1ps
module tb_fifo_lru_page_replacement;

    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 114;
    localparam int CALM_FROM    = N_PHASES * PHASE_ITEMS - 100;
    localparam int LONG_HOLD    = 150;
    localparam int TAIL_CYCLES  = 8;
    localparam int STIM_DEPTH   = 64;
    localparam int EXP_DEPTH    = 64;

    localparam logic       PHASE_POLICY [N_PHASES] = '{flp_pkg::MODE_LRU, flp_pkg::MODE_FIFO,
                                                       flp_pkg::MODE_LRU, flp_pkg::MODE_FIFO,
                                                       flp_pkg::MODE_LRU, flp_pkg::MODE_FIFO,
                                                       flp_pkg::MODE_LRU, flp_pkg::MODE_FIFO,
                                                       flp_pkg::MODE_LRU, flp_pkg::MODE_LRU};
    localparam logic [5:0] PHASE_LIMIT  [N_PHASES] = '{6'd32, 6'd32, 6'd1, 6'd63, 6'd0,
                                                       6'd3, 6'd8, 6'd16, 6'd33, 6'd5};

    typedef enum logic {ROW_REF, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind      kind;
        logic           cfg_index;
        logic [5:0]     cfg_value;
        flp_pkg::t_in   beat;
        logic           typed;
        flp_pkg::t_out  want;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    flp_pkg::t_in              i_in_data;
    logic                      o_out_valid;
    logic                      i_out_stall;
    flp_pkg::t_out             o_out_data;
    logic                      i_cfg_we;
    logic                      i_cfg_index;
    logic [flp_pkg::CFG_W-1:0] i_cfg_data;

    // predictor state
    logic [flp_pkg::PAGE_BITS-1:0] resident [flp_pkg::MAX_FRAMES];
    int                            n_resident;
    logic                          cfg_policy;
    logic [5:0]                    cfg_limit;

    flp_pkg::t_out exp_beats [EXP_DEPTH];
    int            exp_wr;
    int            exp_rd;
    t_stim_row     stim_rows [STIM_DEPTH];
    int            n_stim;
    int            mismatches;
    logic          calm;
    logic          hold_asked;
    logic          hold_done;

    fifo_lru_page_replacement dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic flp_pkg::t_out predict_ref(input flp_pkg::t_in beat);
        flp_pkg::t_out res;
        int            cap;
        int            hit_at;
        int            i;
        res = '0;
        cap = (cfg_limit == 6'd0) ? 1 : ((cfg_limit > flp_pkg::MAX_FRAMES) ?
                                         flp_pkg::MAX_FRAMES : int'(cfg_limit));
        if (beat.restart) n_resident = 0;
        hit_at = -1;
        for (i = 0; i < n_resident; i++) begin
            if (hit_at < 0 && resident[i] == beat.page_number) hit_at = i;
        end
        if (hit_at >= 0) begin
            res.hit = 1'b1;
            if (cfg_policy == flp_pkg::MODE_LRU) begin
                for (i = hit_at; i < n_resident - 1; i++) resident[i] = resident[i + 1];
                resident[n_resident - 1] = beat.page_number;
            end
        end else begin
            if (n_resident >= cap && n_resident > 0) begin
                res.evicted_valid = 1'b1;
                res.evicted_page  = resident[0];
                for (i = 0; i < n_resident - 1; i++) resident[i] = resident[i + 1];
                n_resident--;
            end
            if (n_resident < flp_pkg::MAX_FRAMES) begin
                resident[n_resident] = beat.page_number;
                n_resident++;
            end
        end
        res.occupancy = n_resident[flp_pkg::CNT_W-1:0];
        return res;
    endfunction

    task automatic add_ref(input logic [15:0] page, input logic restart, input logic typed,
                           input flp_pkg::t_out want);
        t_stim_row row;
        row.kind             = ROW_REF;
        row.cfg_index        = flp_pkg::CFG_POLICY_MODE;
        row.cfg_value        = '0;
        row.beat.page_number = page;
        row.beat.restart     = restart;
        row.typed            = typed;
        row.want             = want;
        stim_rows[n_stim]    = row;
        n_stim++;
    endtask

    task automatic add_cfg(input logic index, input logic [5:0] value);
        t_stim_row row;
        row.kind          = ROW_CFG;
        row.cfg_index     = index;
        row.cfg_value     = value;
        row.beat          = '0;
        row.typed         = 1'b0;
        row.want          = '0;
        stim_rows[n_stim] = row;
        n_stim++;
    endtask

    task automatic issue_ref(input flp_pkg::t_in beat, input logic typed,
                             input flp_pkg::t_out want);
        flp_pkg::t_out model;
        logic          taken;
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            if (taken) begin
                model = predict_ref(beat);
                exp_beats[exp_wr % EXP_DEPTH] = typed ? want : model;
                exp_wr++;
            end
            @(posedge i_clk);
        end
    endtask

    task automatic idle_in(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [5:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (index == flp_pkg::CFG_POLICY_MODE) cfg_policy = value[0];
        else cfg_limit = value;
    endtask

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin : result_check
        flp_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                $display("%0t ns: result expected none, got %0h", $time, o_out_data);
                mismatches++;
            end else begin
                want = exp_beats[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("hit", 32'(want.hit), 32'(o_out_data.hit));
                check_field("evicted_valid", 32'(want.evicted_valid),
                            32'(o_out_data.evicted_valid));
                check_field("evicted_page", 32'(want.evicted_page),
                            32'(o_out_data.evicted_page));
                check_field("occupancy", 32'(want.occupancy), 32'(o_out_data.occupancy));
            end
        end
    end

    initial begin : sink
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_asked && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(19, 1)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(25, 1)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("fifo_lru_page_replacement: mismatch");
        $finish;
    end

    initial begin : source
        logic [flp_pkg::PAGE_BITS-1:0] pool [64];
        int                            pool_n;
        int                            sent;
        int                            p;
        int                            k;
        int                            r;
        flp_pkg::t_in                  beat;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = flp_pkg::CFG_POLICY_MODE;
        i_cfg_data  = '0;
        exp_wr      = 0;
        exp_rd      = 0;
        n_stim      = 0;
        mismatches  = 0;
        calm        = 1'b0;
        hold_asked  = 1'b0;
        hold_done   = 1'b0;
        n_resident  = 0;
        cfg_policy  = flp_pkg::MODE_FIFO;
        cfg_limit   = 6'd32;
        for (k = 0; k < flp_pkg::MAX_FRAMES; k++) resident[k] = '0;

        add_ref(16'h0000, 1'b1, 1'b1, '{1'b0, 1'b0, 16'h0000, 6'd1});
        add_ref(16'hFFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 6'd2});
        add_ref(16'h0000, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 6'd2});
        add_cfg(flp_pkg::CFG_FRAME_LIMIT, 6'd2);
        add_ref(16'h1234, 1'b0, 1'b1, '{1'b0, 1'b1, 16'h0000, 6'd2});
        add_cfg(flp_pkg::CFG_POLICY_MODE, {5'd0, flp_pkg::MODE_LRU});
        add_ref(16'hFFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 6'd2});
        add_ref(16'h5555, 1'b0, 1'b1, '{1'b0, 1'b1, 16'h1234, 6'd2});
        add_ref(16'hFFFF, 1'b0, 1'b0, '0);
        add_cfg(flp_pkg::CFG_FRAME_LIMIT, 6'd0);
        add_ref(16'hAAAA, 1'b0, 1'b0, '0);
        add_ref(16'hFFFF, 1'b0, 1'b0, '0);
        add_ref(16'h8001, 1'b0, 1'b0, '0);
        add_cfg(flp_pkg::CFG_FRAME_LIMIT, 6'd63);
        add_ref(16'h7FFE, 1'b1, 1'b1, '{1'b0, 1'b0, 16'h0000, 6'd1});
        add_ref(16'h8001, 1'b0, 1'b0, '0);
        add_cfg(flp_pkg::CFG_POLICY_MODE, {5'd0, flp_pkg::MODE_FIFO});
        add_ref(16'h7FFE, 1'b0, 1'b0, '0);
        add_cfg(flp_pkg::CFG_FRAME_LIMIT, 6'd1);
        add_ref(16'h0001, 1'b1, 1'b1, '{1'b0, 1'b0, 16'h0000, 6'd1});
        add_ref(16'h0002, 1'b0, 1'b1, '{1'b0, 1'b1, 16'h0001, 6'd1});
        add_ref(16'h0002, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 6'd1});
        add_cfg(flp_pkg::CFG_FRAME_LIMIT, 6'd32);
        add_ref(16'hAAAA, 1'b1, 1'b1, '{1'b0, 1'b0, 16'h0000, 6'd1});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < n_stim; r++) begin
            if (stim_rows[r].kind == ROW_CFG) begin
                write_reg(stim_rows[r].cfg_index, stim_rows[r].cfg_value);
            end else begin
                issue_ref(stim_rows[r].beat, stim_rows[r].typed, stim_rows[r].want);
                if ($urandom_range(3) == 0) idle_in($urandom_range(19, 1));
            end
        end

        sent   = 0;
        pool_n = 1;
        for (p = 0; p < N_PHASES; p++) begin
            write_reg(flp_pkg::CFG_POLICY_MODE, {5'd0, PHASE_POLICY[p]});
            write_reg(flp_pkg::CFG_FRAME_LIMIT, PHASE_LIMIT[p]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 40 == 0) begin
                    pool_n = $urandom_range(40, 1);
                    for (int j = 0; j < pool_n; j++) pool[j] = 16'($urandom_range(16'hFFFF));
                end
                if (p == 0 && k == 20) hold_asked = 1'b1;
                if (p == 2 && k == 60) drain();
                beat.restart     = ($urandom_range(49) == 0);
                beat.page_number = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                                            : pool[$urandom_range(pool_n - 1)];
                issue_ref(beat, 1'b0, '0);
                sent++;
                if (sent >= CALM_FROM) calm = 1'b1;
                if (!calm && !(hold_asked && !hold_done) && $urandom_range(7) == 0)
                    idle_in($urandom_range(19, 1));
            end
        end

        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("fifo_lru_page_replacement: match");
        end else begin
            $display("fifo_lru_page_replacement: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
src/flp_pkg.sv
src/flp_cell.sv
src/fifo_lru_page_replacement.sv
tb/sv/tb_fifo_lru_page_replacement.sv
